### hdl/tap_pkg.sv
package tap_pkg;

  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_MAX_TILE  = 64;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_W    = 8;
  localparam int DIM_W    = 13;   // frame_width / frame_height register width
  localparam int TS_W     = 7;    // tile_size register width
  localparam int ROW_W    = 12;
  localparam int IDX_W    = 12;   // tile index width on the result
  localparam int SUM_W    = 32;
  localparam int QUO_W    = 8;
  localparam int DIV_W    = 2 * TS_W;
  localparam int REM_W    = DIV_W + QUO_W;
  localparam int NCHAN    = 3;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TILE_SIZE    = 2'd2;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [TS_W-1:0]  RST_TILE_SIZE    = 7'd15;

  typedef logic [NCHAN-1:0][SUM_W-1:0] sums_t;

  typedef struct packed {
    logic [IDX_W-1:0] tx;
    logic [IDX_W-1:0] ty;
    logic             fd;
    logic [DIV_W-1:0] div;
  } tile_tag_t;

  typedef struct packed {
    tile_tag_t tag;
    sums_t     sum;
  } head_t;

  typedef struct packed {
    tile_tag_t                        tag;
    logic [NCHAN-1:0]                 sat;
    logic [NCHAN-1:0][REM_W-1:0]      rem;
    logic [NCHAN-1:0][QUO_W-1:0]      quo;
  } div_stage_t;

endpackage

### hdl/tile_average_pixelator_unit.sv
// Block-average mosaic: takes one 3-channel pixel per unstalled clock in raster order and
// emits one result per tile (indices plus the three truncated channel averages,
// sum / tile_size^2, saturated at 255) once the tile's bottom-right pixel is in;
// tiles cut by the frame edge count missing pixels as zero. Sustained rate is
// one pixel per clock while in_stall is low, set by the single read-modify-write
// per pixel on the tile-column sum memory (MAX_WIDTH entries, registered read,
// same-entry hazards forwarded). A result passes the accumulate stage and the
// divider head, then an 8-step pipelined divider, into the output register.
// After reset the sum memory is cleared one entry per cycle, and in_stall stays
// high until the clear is done; configuration writes are taken during that time.
module tile_average_pixelator_unit #(
  parameter int MAX_WIDTH = tap_pkg::DEF_MAX_WIDTH,
  parameter int MAX_TILE  = tap_pkg::DEF_MAX_TILE
) (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tap_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tap_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tap_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tap_pkg::PIX_W-1:0]       chan_a,
  input  logic [tap_pkg::PIX_W-1:0]       chan_b,
  input  logic [tap_pkg::PIX_W-1:0]       chan_c,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tap_pkg::IDX_W-1:0]       tile_x,
  output logic [tap_pkg::IDX_W-1:0]       tile_y,
  output logic [tap_pkg::PIX_W-1:0]       avg_a,
  output logic [tap_pkg::PIX_W-1:0]       avg_b,
  output logic [tap_pkg::PIX_W-1:0]       avg_c,
  output logic                            frame_done
);
  import tap_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int FW_CAP = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
  localparam int TS_CAP = (MAX_TILE < 127) ? MAX_TILE : 127;
  localparam int NSTEP  = QUO_W + 1;

  // configuration
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [TS_W-1:0]  tile_size;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      tile_size    <= RST_TILE_SIZE;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[DIM_W-1:0];
        REG_TILE_SIZE:    tile_size    <= pwdata[TS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height);
      REG_TILE_SIZE:    prdata = CFG_DATA_W'(tile_size);
      default:          prdata = '0;
    endcase
  end

  // flow control: the whole pipe moves when the output register can load
  logic adv;
  logic accept;
  logic clearing;
  logic [ADDR_W-1:0] clr_addr;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = clearing || !adv;
  assign accept   = in_valid && !in_stall;

  // position counters
  logic [DIM_W-1:0] pixel_column;
  logic [ROW_W-1:0] pixel_row;
  logic [TS_W-1:0]  column_in_tile;
  logic [TS_W-1:0]  row_in_tile;
  logic [DIM_W-1:0] tile_column_index;
  logic [ROW_W-1:0] tile_row_index;

  logic [DIM_W-1:0] fw_eff;
  logic [DIM_W-1:0] fh_eff;
  logic [TS_W-1:0]  ts_eff;
  logic line_end, last_row, frame_end, col_end, row_end, tile_wrap;
  logic [ADDR_W-1:0] raddr;

  always_comb begin
    if (frame_width == '0)                   fw_eff = DIM_W'(1);
    else if (frame_width > DIM_W'(FW_CAP))   fw_eff = DIM_W'(FW_CAP);
    else                                     fw_eff = frame_width;
    if (frame_height == '0)                  fh_eff = DIM_W'(1);
    else if (frame_height > DIM_W'(MAX_HEIGHT)) fh_eff = DIM_W'(MAX_HEIGHT);
    else                                     fh_eff = frame_height;
    if (tile_size == '0)                     ts_eff = TS_W'(1);
    else if (tile_size > TS_W'(TS_CAP))      ts_eff = TS_W'(TS_CAP);
    else                                     ts_eff = tile_size;
  end

  assign line_end  = pixel_column >= fw_eff - DIM_W'(1);
  assign last_row  = DIM_W'(pixel_row) >= fh_eff - DIM_W'(1);
  assign frame_end = line_end && last_row;
  assign tile_wrap = column_in_tile >= ts_eff - TS_W'(1);
  assign col_end   = line_end || tile_wrap;
  assign row_end   = last_row || (row_in_tile >= ts_eff - TS_W'(1));

  always_comb begin
    if (32'(tile_column_index) >= MAX_WIDTH) raddr = ADDR_W'(MAX_WIDTH - 1);
    else                                     raddr = ADDR_W'(tile_column_index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column      <= '0;
      pixel_row         <= '0;
      column_in_tile    <= '0;
      row_in_tile       <= '0;
      tile_column_index <= '0;
      tile_row_index    <= '0;
    end else if (accept) begin
      if (line_end) begin
        pixel_column      <= '0;
        column_in_tile    <= '0;
        tile_column_index <= '0;
        if (frame_end) begin
          pixel_row      <= '0;
          row_in_tile    <= '0;
          tile_row_index <= '0;
        end else begin
          pixel_row <= pixel_row + ROW_W'(1);
          if (row_in_tile >= ts_eff - TS_W'(1)) begin
            row_in_tile    <= '0;
            tile_row_index <= tile_row_index + ROW_W'(1);
          end else begin
            row_in_tile <= row_in_tile + TS_W'(1);
          end
        end
      end else begin
        pixel_column <= pixel_column + DIM_W'(1);
        if (tile_wrap) begin
          column_in_tile    <= '0;
          tile_column_index <= tile_column_index + DIM_W'(1);
        end else begin
          column_in_tile <= column_in_tile + TS_W'(1);
        end
      end
    end
  end

  // stage 1: memory read data arrives, accumulate and write back
  logic                          s1_valid;
  logic                          s1_emit;
  logic [ADDR_W-1:0]             s1_addr;
  logic [NCHAN-1:0][PIX_W-1:0]   s1_px;
  tile_tag_t                     s1_tag;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit    <= col_end && row_end;
      s1_addr    <= raddr;
      s1_px      <= {chan_c, chan_b, chan_a};
      s1_tag.tx  <= tile_column_index[IDX_W-1:0];
      s1_tag.ty  <= tile_row_index;
      s1_tag.fd  <= frame_end;
      s1_tag.div <= DIV_W'(ts_eff) * DIV_W'(ts_eff);
    end
  end

  sums_t mem [0:MAX_WIDTH-1];
  sums_t rd_data;
  logic              lw_valid;
  logic [ADDR_W-1:0] lw_addr;
  sums_t             lw_data;
  sums_t             old_sum;
  sums_t             new_sum;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  sums_t             mem_wdata;

  always_comb begin
    logic [SUM_W:0] s;
    // the write issued on the edge of our read is not seen by that read
    old_sum = (lw_valid && lw_addr == s1_addr) ? lw_data : rd_data;
    for (int c = 0; c < NCHAN; c++) begin
      s = {1'b0, old_sum[c]} + (SUM_W + 1)'(s1_px[c]);
      new_sum[c] = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    end
  end

  assign mem_we    = clearing || (adv && s1_valid);
  assign mem_waddr = clearing ? clr_addr : s1_addr;
  assign mem_wdata = (clearing || s1_emit) ? '0 : new_sum;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (accept) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      lw_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == ADDR_W'(MAX_WIDTH - 1)) clearing <= 1'b0;
        else clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (adv && s1_valid) lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      lw_addr <= s1_addr;
      lw_data <= mem_wdata;
    end
  end

  // divider: saturation check, then one quotient bit per stage
  logic       hd_valid;
  head_t      hd;
  logic [NSTEP-1:0] ds_valid;
  div_stage_t ds [0:NSTEP-1];
  div_stage_t pre;
  div_stage_t step_res [0:NSTEP-2];

  always_ff @(posedge clk) begin
    if (rst) begin
      hd_valid <= 1'b0;
      ds_valid <= '0;
    end else if (adv) begin
      hd_valid <= s1_valid && s1_emit;
      ds_valid <= {ds_valid[NSTEP-2:0], hd_valid};
    end
  end

  always_comb begin
    pre.tag = hd.tag;
    pre.quo = '0;
    for (int c = 0; c < NCHAN; c++) begin
      pre.sat[c] = hd.sum[c] >= (SUM_W'(hd.tag.div) << QUO_W);
      pre.rem[c] = pre.sat[c] ? '0 : hd.sum[c][REM_W-1:0];
    end
  end

  always_comb begin
    logic [REM_W-1:0] shd;
    for (int k = 0; k < NSTEP - 1; k++) begin
      step_res[k] = ds[k];
      for (int c = 0; c < NCHAN; c++) begin
        shd = REM_W'(ds[k].tag.div) << (QUO_W - 1 - k);
        if (ds[k].rem[c] >= shd) begin
          step_res[k].rem[c] = ds[k].rem[c] - shd;
          step_res[k].quo[c][QUO_W-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hd.tag <= s1_tag;
      hd.sum <= new_sum;
      ds[0]  <= pre;
      for (int k = 0; k < NSTEP - 1; k++) ds[k+1] <= step_res[k];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= ds_valid[NSTEP-1];
  end

  always_ff @(posedge clk) begin
    if (adv && ds_valid[NSTEP-1]) begin
      tile_x     <= ds[NSTEP-1].tag.tx;
      tile_y     <= ds[NSTEP-1].tag.ty;
      frame_done <= ds[NSTEP-1].tag.fd;
      avg_a <= ds[NSTEP-1].sat[0] ? {PIX_W{1'b1}} : ds[NSTEP-1].quo[0];
      avg_b <= ds[NSTEP-1].sat[1] ? {PIX_W{1'b1}} : ds[NSTEP-1].quo[1];
      avg_c <= ds[NSTEP-1].sat[2] ? {PIX_W{1'b1}} : ds[NSTEP-1].quo[2];
    end
  end

  a_no_pixel_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid)
    else $error("pixel in accumulate stage during memory clear");

  a_emit_enters_divider: assert property (@(posedge clk) disable iff (rst)
    adv && s1_valid && s1_emit |=> hd_valid)
    else $error("finished tile lost before divider");

  a_remainder_below_divisor: assert property (@(posedge clk) disable iff (rst)
    ds_valid[NSTEP-1] |->
      ds[NSTEP-1].rem[0] < REM_W'(ds[NSTEP-1].tag.div) &&
      ds[NSTEP-1].rem[1] < REM_W'(ds[NSTEP-1].tag.div) &&
      ds[NSTEP-1].rem[2] < REM_W'(ds[NSTEP-1].tag.div))
    else $error("divider remainder not below divisor");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(avg_a) && $stable(tile_x))
    else $error("stalled result changed");

endmodule

### test/tile_average_pixelator_unit_tb.sv
module tile_average_pixelator_unit_tb;
  import tap_pkg::*;

  localparam int RAND_ITEMS  = 1750;
  localparam int SETTLE      = 32;     // covers the result latency with margin
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4 * DEF_MAX_WIDTH + 1000;  // sum clear after reset dominates
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] c;
  } pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0] tile_x;
    logic [IDX_W-1:0] tile_y;
    logic [PIX_W-1:0] avg_a;
    logic [PIX_W-1:0] avg_b;
    logic [PIX_W-1:0] avg_c;
    logic             frame_done;
  } tile_res_t;

  typedef struct packed {
    pixel_t    px;
    logic      typed;
    tile_res_t want;
  } feed_item_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_TILE} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [1:0]       reg_idx;
    logic [31:0]      value;
    pixel_t           px;
    tile_res_t        want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] chan_a = '0;
  logic [PIX_W-1:0] chan_b = '0;
  logic [PIX_W-1:0] chan_c = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] tile_x;
  logic [IDX_W-1:0] tile_y;
  logic [PIX_W-1:0] avg_a;
  logic [PIX_W-1:0] avg_b;
  logic [PIX_W-1:0] avg_c;
  logic             frame_done;

  tile_average_pixelator_unit u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .chan_a(chan_a), .chan_b(chan_b), .chan_c(chan_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .tile_x(tile_x), .tile_y(tile_y),
    .avg_a(avg_a), .avg_b(avg_b), .avg_c(avg_c), .frame_done(frame_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register mirror
  logic [DIM_W-1:0] cfg_width  = RST_FRAME_WIDTH;
  logic [DIM_W-1:0] cfg_height = RST_FRAME_HEIGHT;
  logic [TS_W-1:0]  cfg_tile   = RST_TILE_SIZE;

  // mosaic state
  logic [SUM_W-1:0] col_sum [DEF_MAX_WIDTH][NCHAN];
  int unsigned px_col = 0, px_row = 0;
  int unsigned in_tile_col = 0, in_tile_row = 0;
  int unsigned col_tile_idx = 0, row_tile_idx = 0;

  feed_item_t feed_q [$];
  tile_res_t  tile_exp_q [$];
  feed_item_t on_bus;

  int  mismatches = 0;
  int  pix_taken = 0;
  int  tiles_seen = 0;
  int  frames_seen = 0;
  int  cfg_writes = 0;
  int  quiet_cycles = 0;
  bit  hold_req = 1'b0;
  bit  hold_used = 1'b0;
  int  hold_left = 0;
  logic calm;

  assign calm = (pix_taken >= 700) && (pix_taken < 1000);

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic int unsigned limit_to(input int unsigned v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // one pixel through the mosaic; returns 1 when a tile finishes
  function automatic bit mosaic_step(input pixel_t px, output tile_res_t res);
    int unsigned fw, fh, ts, slot, q;
    logic [PIX_W-1:0] pv [NCHAN];
    logic [PIX_W-1:0] avg [NCHAN];
    logic [SUM_W:0] acc;
    bit line_end, frame_end, col_end, row_end;
    fw = limit_to(cfg_width, DEF_MAX_WIDTH);
    fh = limit_to(cfg_height, MAX_HEIGHT);
    ts = limit_to(cfg_tile, DEF_MAX_TILE);
    slot = (col_tile_idx >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : col_tile_idx;
    pv[0] = px.a;
    pv[1] = px.b;
    pv[2] = px.c;
    for (int c = 0; c < NCHAN; c++) begin
      acc = {1'b0, col_sum[slot][c]} + pv[c];
      col_sum[slot][c] = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
    end

    line_end  = px_col >= fw - 1;
    frame_end = line_end && (px_row >= fh - 1);
    col_end   = line_end || (in_tile_col >= ts - 1);
    row_end   = (px_row >= fh - 1) || (in_tile_row >= ts - 1);

    res = '0;
    if (col_end && row_end) begin
      for (int c = 0; c < NCHAN; c++) begin
        q = col_sum[slot][c] / (ts * ts);
        avg[c] = (q > 255) ? 8'hff : q[7:0];
        col_sum[slot][c] = '0;
      end
      res.tile_x     = IDX_W'(col_tile_idx);
      res.tile_y     = IDX_W'(row_tile_idx);
      res.avg_a      = avg[0];
      res.avg_b      = avg[1];
      res.avg_c      = avg[2];
      res.frame_done = frame_end;
    end

    if (line_end) begin
      px_col = 0;
      in_tile_col = 0;
      col_tile_idx = 0;
      if (frame_end) begin
        px_row = 0;
        in_tile_row = 0;
        row_tile_idx = 0;
      end else begin
        px_row++;
        if (in_tile_row >= ts - 1) begin
          in_tile_row = 0;
          row_tile_idx++;
        end else begin
          in_tile_row++;
        end
      end
    end else begin
      px_col++;
      if (in_tile_col >= ts - 1) begin
        in_tile_col = 0;
        col_tile_idx++;
      end else begin
        in_tile_col++;
      end
    end
    return col_end && row_end;
  endfunction

  // pixel source
  always @(posedge clk) begin : pixel_feed
    tile_res_t predicted;
    bit        has_tile;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        has_tile = mosaic_step(on_bus.px, predicted);
        pix_taken++;
        if (on_bus.typed) tile_exp_q.push_back(on_bus.want);
        else if (has_tile) tile_exp_q.push_back(predicted);
      end
      if (!in_valid || !in_stall) begin
        if (feed_q.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          on_bus = feed_q.pop_front();
          in_valid <= 1'b1;
          chan_a   <= on_bus.px.a;
          chan_b   <= on_bus.px.b;
          chan_c   <= on_bus.px.c;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result sink with random stalls and one long hold-off
  always @(posedge clk) begin : tile_sink
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin : tile_check
    tile_res_t want;
    if (!rst && out_valid && !out_stall) begin
      tiles_seen++;
      if (frame_done) frames_seen++;
      if (tile_exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected tile x=%0d y=%0d", tile_x, tile_y));
      end else begin
        want = tile_exp_q.pop_front();
        if (tile_x !== want.tile_x)
          report_mismatch($sformatf("tile_x got %0d want %0d", tile_x, want.tile_x));
        if (tile_y !== want.tile_y)
          report_mismatch($sformatf("tile_y got %0d want %0d", tile_y, want.tile_y));
        if (avg_a !== want.avg_a)
          report_mismatch($sformatf("avg_a got %0d want %0d", avg_a, want.avg_a));
        if (avg_b !== want.avg_b)
          report_mismatch($sformatf("avg_b got %0d want %0d", avg_b, want.avg_b));
        if (avg_c !== want.avg_c)
          report_mismatch($sformatf("avg_c got %0d want %0d", avg_c, want.avg_c));
        if (frame_done !== want.frame_done)
          report_mismatch($sformatf("frame_done got %0b want %0b", frame_done,
                                    want.frame_done));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d cycles without a transaction", quiet_cycles);
      $display("** tile_average_pixelator_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_readback(input logic [1:0] idx);
    logic [31:0] got, want;
    apb_access(idx, 1'b0, '0, got);
    case (idx)
      REG_FRAME_WIDTH:  want = 32'(cfg_width);
      REG_FRAME_HEIGHT: want = 32'(cfg_height);
      default:          want = 32'(cfg_tile);
    endcase
    if (got !== want)
      report_mismatch($sformatf("register %0d reads %0d want %0d", idx, got, want));
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] ignored;
    apb_access(idx, 1'b1, val, ignored);
    case (idx)
      REG_FRAME_WIDTH:  cfg_width  = val[DIM_W-1:0];
      REG_FRAME_HEIGHT: cfg_height = val[DIM_W-1:0];
      default:          cfg_tile   = val[TS_W-1:0];
    endcase
    cfg_writes++;
    reg_readback(idx);
  endtask

  // wait until the block has nothing in flight
  task automatic flush_pipe();
    while (feed_q.size() != 0 || in_valid || tile_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.value = val;
    return r;
  endfunction

  function automatic dir_row_t pix_row(input logic [7:0] a, b, c);
    dir_row_t r;
    r = '0;
    r.kind = ROW_PIX;
    r.px = '{a, b, c};
    return r;
  endfunction

  function automatic dir_row_t tile_row(input logic [7:0] a, b, c, input int tx, ty,
                                        input logic [7:0] qa, qb, qc, input bit fd);
    dir_row_t r;
    r = pix_row(a, b, c);
    r.kind = ROW_TILE;
    r.want = '{IDX_W'(tx), IDX_W'(ty), qa, qb, qc, fd};
    return r;
  endfunction

  initial begin : main
    dir_row_t   plan [$];
    feed_item_t item;
    int kind, w, h, ts, items, phase, rand_pix;
    for (int i = 0; i < DEF_MAX_WIDTH; i++)
      for (int c = 0; c < NCHAN; c++) col_sum[i][c] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    reg_readback(REG_FRAME_WIDTH);
    reg_readback(REG_FRAME_HEIGHT);
    reg_readback(REG_TILE_SIZE);

    plan = {
      // 1x1 tiles on a 2x2 frame: every pixel is its own tile
      cfg_row(REG_TILE_SIZE, 32'd1), cfg_row(REG_FRAME_WIDTH, 32'd2),
      cfg_row(REG_FRAME_HEIGHT, 32'd2),
      tile_row(8'h00, 8'h00, 8'h00, 0, 0, 8'h00, 8'h00, 8'h00, 1'b0),
      tile_row(8'hff, 8'hff, 8'hff, 1, 0, 8'hff, 8'hff, 8'hff, 1'b0),
      tile_row(8'h55, 8'haa, 8'h0f, 0, 1, 8'h55, 8'haa, 8'h0f, 1'b0),
      tile_row(8'haa, 8'h55, 8'hf0, 1, 1, 8'haa, 8'h55, 8'hf0, 1'b1),
      // 2x2 tiles on 3x3: edge tiles keep the full divisor
      cfg_row(REG_TILE_SIZE, 32'd2), cfg_row(REG_FRAME_WIDTH, 32'd3),
      cfg_row(REG_FRAME_HEIGHT, 32'd3),
      pix_row(8'hff, 8'hff, 8'hff), pix_row(8'hff, 8'hff, 8'hff),
      pix_row(8'hff, 8'hff, 8'hff), pix_row(8'hff, 8'hff, 8'hff),
      tile_row(8'hff, 8'hff, 8'hff, 0, 0, 8'hff, 8'hff, 8'hff, 1'b0),
      tile_row(8'hff, 8'hff, 8'hff, 1, 0, 8'h7f, 8'h7f, 8'h7f, 1'b0),
      pix_row(8'hff, 8'hff, 8'hff),
      tile_row(8'hff, 8'hff, 8'hff, 0, 1, 8'h7f, 8'h7f, 8'h7f, 1'b0),
      tile_row(8'hff, 8'hff, 8'hff, 1, 1, 8'h3f, 8'h3f, 8'h3f, 1'b1),
      // zero registers act as one
      cfg_row(REG_FRAME_WIDTH, 32'd0), cfg_row(REG_FRAME_HEIGHT, 32'd0),
      cfg_row(REG_TILE_SIZE, 32'd0),
      tile_row(8'h12, 8'h34, 8'h56, 0, 0, 8'h12, 8'h34, 8'h56, 1'b1),
      // oversized registers clamp to the limits
      cfg_row(REG_FRAME_WIDTH, 32'd8191), cfg_row(REG_FRAME_HEIGHT, 32'd8191),
      cfg_row(REG_TILE_SIZE, 32'd127),
      pix_row(8'h01, 8'h80, 8'hfe), pix_row(8'h7f, 8'hfe, 8'h01),
      pix_row(8'hc3, 8'h3c, 8'h99)
    };

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        flush_pipe();
        cfg_write(plan[i].reg_idx, plan[i].value);
      end else begin
        item.px    = plan[i].px;
        item.typed = (plan[i].kind == ROW_TILE);
        item.want  = plan[i].want;
        feed_q.push_back(item);
      end
    end

    // random phases; the frame position carries over across register changes
    phase = 0;
    rand_pix = 0;
    while (rand_pix < RAND_ITEMS) begin
      flush_pipe();
      kind = $urandom_range(9);
      case (kind)
        6: begin  // tall narrow frames with the largest tiles
          w  = $urandom_range(1, 3);
          h  = $urandom_range(64, 140);
          ts = $urandom_range(1) ? 64 : 127;
        end
        7: begin  // widest lines
          case ($urandom_range(2))
            0: w = 4096;
            1: w = 8191;
            default: w = $urandom_range(3000, 4095);
          endcase
          h  = $urandom_range(1, 3);
          ts = $urandom_range(1, 3);
        end
        8: begin  // any width and tile size the register widths allow, short frames
          w  = ($urandom_range(3) == 0) ? 0 : $urandom_range(8191);
          h  = ($urandom_range(3) == 0) ? 0 : $urandom_range(20);
          ts = ($urandom_range(3) == 0) ? 0 : $urandom_range(127);
        end
        default: begin
          w  = $urandom_range(1, 20);
          h  = $urandom_range(1, 12);
          ts = $urandom_range(1, 6);
        end
      endcase
      if (phase == 2) begin  // small tiles so results back up behind the hold-off
        w  = 8;
        h  = 8;
        ts = 1;
        kind = 0;
      end

      if (kind == 9) begin  // one register changed mid-frame
        case ($urandom_range(2))
          0: cfg_write(REG_FRAME_WIDTH, w);
          1: cfg_write(REG_FRAME_HEIGHT, h);
          default: cfg_write(REG_TILE_SIZE, ts);
        endcase
      end else if (kind == 8) begin  // junk above the register width is dropped
        cfg_write(REG_FRAME_WIDTH, w | ($urandom_range(1) ? ($urandom() << DIM_W) : 0));
        cfg_write(REG_FRAME_HEIGHT, h | ($urandom_range(1) ? ($urandom() << DIM_W) : 0));
        cfg_write(REG_TILE_SIZE, ts | ($urandom_range(1) ? ($urandom() << TS_W) : 0));
      end else begin
        cfg_write(REG_FRAME_WIDTH, w);
        cfg_write(REG_FRAME_HEIGHT, h);
        cfg_write(REG_TILE_SIZE, ts);
      end

      items = limit_to(cfg_width, DEF_MAX_WIDTH) * limit_to(cfg_height, MAX_HEIGHT);
      if (kind == 6) items = limit_to(cfg_width, DEF_MAX_WIDTH) * 64 + $urandom_range(8);
      else if (items > 260 || kind == 9) items = $urandom_range(20, 160);
      else if (phase != 2 && $urandom_range(3) == 0) items = $urandom_range(1, items);

      if (phase == 2) hold_req = 1'b1;
      for (int i = 0; i < items; i++) begin
        if ($urandom_range(7) == 0) begin
          item.px = '1;
        end else begin
          item.px.a = $urandom_range(255);
          item.px.b = $urandom_range(255);
          item.px.c = $urandom_range(255);
        end
        item.typed = 1'b0;
        item.want  = '0;
        feed_q.push_back(item);
      end
      rand_pix += items;
      phase++;
    end

    flush_pipe();
    $display("covered %0d pixels over %0d phases, %0d tiles out, %0d closing a frame",
             pix_taken, phase, tiles_seen, frames_seen);
    $display("%0d register writes with readback, %0d mismatches", cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("** tile_average_pixelator_unit: PASSED **");
    end else begin
      $display("** tile_average_pixelator_unit: FAILED **");
    end
    $finish;
  end

endmodule
